// File: hw/rtl/modular_inverse_euclid_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the modular inverse block.
// Shared implication forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EUCLID_ASSERT_SVH

// Same-cycle implication.
`define MIE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MIE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mie_pkg.sv
// ---------------------------------------------------------------------------
// mie_pkg
// Widths, types and defaults shared by the modular inverse block.
// ---------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

   // Fixed field widths of the request and response words.
   localparam int VALUE_WIDTH    = 31;
   localparam int COEF_OUT_WIDTH = 32;
   localparam int STEP_WIDTH     = 6;

   // Default width of the coefficient recurrence.
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
      logic qbit;
   } div_stat_type;

   // Commands to the coefficient unit.
   typedef struct packed {
      logic init;
      logic clear_prod;
      logic acc;
      logic qbit;
      logic commit;
   } coef_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/mie_divider.sv
// ---------------------------------------------------------------------------
// mie_divider
// Restoring divider, one quotient bit per cycle, most significant bit first.
// ---------------------------------------------------------------------------
`default_nettype none

module mie_divider #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output mie_pkg::div_stat_type stat,
   output logic      [WIDTH-1:0] remainder
);
   import mie_pkg::*;

   localparam int CountWidth = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]      rem_ff, rem_in;
   logic [WIDTH-1:0]      dvd_ff, dvd_in;
   logic [WIDTH-1:0]      dsr_ff, dsr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [WIDTH:0]        shifted;
   logic [WIDTH:0]        trial;
   logic                  qbit;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign shifted = {rem_ff, dvd_ff[WIDTH-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign qbit    = ~trial[WIDTH];

   // Next-state logic of the iteration.
   always_comb begin
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         dvd_in   = dividend;
         dsr_in   = divisor;
         count_in = CountWidth'(WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
         dvd_in   = {dvd_ff[WIDTH-2:0], 1'b0};
         count_in = count_ff - CountWidth'(1);
         if (count_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.qbit = qbit;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: hw/rtl/mie_coef.sv
// ---------------------------------------------------------------------------
// mie_coef
// Bezout coefficient recurrence with a bit-serial quotient product.
// ---------------------------------------------------------------------------
`default_nettype none

module mie_coef #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire mie_pkg::coef_ctl_type   ctl,
   output logic signed [DATA_WIDTH-1:0] coef
);
   import mie_pkg::*;

   logic signed [DATA_WIDTH-1:0] prev2_ff, prev2_in;
   logic signed [DATA_WIDTH-1:0] prev_ff, prev_in;
   logic signed [DATA_WIDTH-1:0] prod_ff, prod_in;

   // The product q * prev is built by Horner's rule as quotient bits arrive.
   always_comb begin
      prev2_in = prev2_ff;
      prev_in  = prev_ff;
      prod_in  = prod_ff;
      if (ctl.init) begin
         prev2_in = '0;
         prev_in  = DATA_WIDTH'(1);
         prod_in  = '0;
      end else begin
         if (ctl.clear_prod) begin
            prod_in = '0;
         end else if (ctl.acc) begin
            prod_in = (prod_ff <<< 1) + (ctl.qbit ? prev_ff : '0);
         end
         if (ctl.commit) begin
            prev2_in = prev_ff;
            prev_in  = prev2_ff - prod_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev2_ff <= prev2_in;
      prev_ff  <= prev_in;
      prod_ff  <= prod_in;
   end

   assign coef = prev_ff;

endmodule

`default_nettype wire

// File: hw/rtl/modular_inverse_euclid.sv
// ---------------------------------------------------------------------------
// modular_inverse_euclid
// Modular inverse by the extended Euclidean algorithm on a shared divider.
// ---------------------------------------------------------------------------
// Usage: a request word carries value and modulus on req_ with valid and
// ready. The block runs Euclid's algorithm, one restoring division per step
// on a single shared divider, while a small sequencer updates the Bezout
// coefficient from the quotient bits as they come out. A last division by
// the modulus reduces the coefficient when an inverse exists and the
// modulus is not zero. The divider is DivWidth bits wide, where DivWidth
// is the larger of 31 and DATA_WIDTH.
// One request is worked on at a time; req_ready is high only when idle.
// The response word waits in an output register on rsp_; a new request is
// taken while it waits, and a finished result stalls until the receiver
// takes the previous one.
// Reset is synchronous and returns the sequencer to idle with no response.
// ---------------------------------------------------------------------------
`default_nettype none
`include "modular_inverse_euclid_assert.svh"

module modular_inverse_euclid #(
   parameter int DATA_WIDTH = mie_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [mie_pkg::VALUE_WIDTH-1:0] req_value,
   input  wire logic        [mie_pkg::VALUE_WIDTH-1:0] req_modulus,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic        [mie_pkg::VALUE_WIDTH-1:0]    rsp_gcd_value,
   output logic                                      rsp_inverse_exists,
   output logic signed [mie_pkg::COEF_OUT_WIDTH-1:0] rsp_bezout_coefficient,
   output logic        [mie_pkg::VALUE_WIDTH-1:0]    rsp_inverse,
   output logic        [mie_pkg::STEP_WIDTH-1:0]     rsp_step_count
);
   import mie_pkg::*;

   localparam int DivWidth = (DATA_WIDTH > VALUE_WIDTH) ? DATA_WIDTH : VALUE_WIDTH;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_DIV   = 5'b00100,
      S_RED   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [VALUE_WIDTH-1:0]     a_ff, a_in;
   logic [VALUE_WIDTH-1:0]     b_ff, b_in;
   logic [VALUE_WIDTH-1:0]     m_ff, m_in;
   logic [STEP_WIDTH-1:0]      steps_ff, steps_in;
   logic [VALUE_WIDTH-1:0]     inv_ff, inv_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]     rsp_gcd_ff, rsp_gcd_in;
   logic                       rsp_exists_ff, rsp_exists_in;
   logic [COEF_OUT_WIDTH-1:0]  rsp_coef_ff, rsp_coef_in;
   logic [VALUE_WIDTH-1:0]     rsp_inv_ff, rsp_inv_in;
   logic [STEP_WIDTH-1:0]      rsp_steps_ff, rsp_steps_in;

   logic                       div_start;
   logic [DivWidth-1:0]        div_dividend;
   logic [DivWidth-1:0]        div_divisor;
   div_stat_type               div_stat;
   logic [DivWidth-1:0]        div_rem;
   coef_ctl_type               coef_ctl;
   logic signed [DATA_WIDTH-1:0] coef_raw;
   logic signed [DATA_WIDTH-1:0] coef_sel;
   logic        [DATA_WIDTH-1:0] coef_mag;
   logic signed [63:0]         coef_ext;
   logic                       exists;
   logic [VALUE_WIDTH-1:0]     red_rem;
   logic [VALUE_WIDTH-1:0]     red_inv;

   // Shared divider and coefficient recurrence.
   mie_divider #(
      .WIDTH (DivWidth)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   mie_coef #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_coef (
      .clock (clock),
      .ctl   (coef_ctl),
      .coef  (coef_raw)
   );

   // Final coefficient, its magnitude and the reduced inverse.
   assign coef_sel = (steps_ff == '0) ? '0 : coef_raw;
   assign coef_mag = coef_sel[DATA_WIDTH-1] ? DATA_WIDTH'(-coef_sel) : DATA_WIDTH'(coef_sel);
   assign coef_ext = 64'(coef_sel);
   assign exists   = (a_ff == VALUE_WIDTH'(1));
   assign red_rem  = div_rem[VALUE_WIDTH-1:0];
   assign red_inv  = (coef_sel[DATA_WIDTH-1] && (red_rem != '0)) ? (m_ff - red_rem) : red_rem;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      m_in          = m_ff;
      steps_in      = steps_ff;
      inv_in        = inv_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_gcd_in    = rsp_gcd_ff;
      rsp_exists_in = rsp_exists_ff;
      rsp_coef_in   = rsp_coef_ff;
      rsp_inv_in    = rsp_inv_ff;
      rsp_steps_in  = rsp_steps_ff;
      div_start     = 1'b0;
      div_dividend  = DivWidth'(a_ff);
      div_divisor   = DivWidth'(b_ff);
      coef_ctl      = '0;
      coef_ctl.qbit = div_stat.qbit;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a_in          = req_modulus;
               b_in          = req_value;
               m_in          = req_modulus;
               steps_in      = '0;
               coef_ctl.init = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (b_ff == '0) begin
               if (exists && (m_ff != '0)) begin
                  div_start    = 1'b1;
                  div_dividend = DivWidth'(coef_mag);
                  div_divisor  = DivWidth'(m_ff);
                  state_in     = S_RED;
               end else begin
                  inv_in   = '0;
                  state_in = S_OUT;
               end
            end else begin
               div_start           = 1'b1;
               coef_ctl.clear_prod = 1'b1;
               state_in            = S_DIV;
            end
         end
         S_DIV: begin
            coef_ctl.acc = div_stat.busy;
            if (div_stat.done) begin
               a_in            = b_ff;
               b_in            = red_rem;
               steps_in        = steps_ff + STEP_WIDTH'(1);
               coef_ctl.commit = (red_rem != '0);
               state_in        = S_CHECK;
            end
         end
         S_RED: begin
            if (div_stat.done) begin
               inv_in   = red_inv;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_gcd_in    = a_ff;
               rsp_exists_in = exists;
               rsp_coef_in   = coef_ext[COEF_OUT_WIDTH-1:0];
               rsp_inv_in    = inv_ff;
               rsp_steps_in  = steps_ff + STEP_WIDTH'(1);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response word registers.
   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      m_ff          <= m_in;
      steps_ff      <= steps_in;
      inv_ff        <= inv_in;
      rsp_gcd_ff    <= rsp_gcd_in;
      rsp_exists_ff <= rsp_exists_in;
      rsp_coef_ff   <= rsp_coef_in;
      rsp_inv_ff    <= rsp_inv_in;
      rsp_steps_ff  <= rsp_steps_in;
   end

   assign req_ready              = (state_ff == S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_gcd_value          = rsp_gcd_ff;
   assign rsp_inverse_exists     = rsp_exists_ff;
   assign rsp_bezout_coefficient = rsp_coef_ff;
   assign rsp_inverse            = rsp_inv_ff;
   assign rsp_step_count         = rsp_steps_ff;

   // The divider is never running while a new word can be taken.
   `MIE_ASSERT_SAME(a_idle_div, req_ready, !div_stat.busy, "divider busy while idle")
   // A division finishes only in a state that waits for it.
   `MIE_ASSERT_SAME(a_done_state, div_stat.done, (state_ff == S_DIV) || (state_ff == S_RED),
      "division finished in an unexpected state")
   // A response word appears only from the output state.
   `MIE_ASSERT_SAME(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff == S_OUT),
      "response raised outside the output state")
   // A started request leaves idle in the next cycle.
   `MIE_ASSERT_NEXT(a_accept, req_valid && req_ready, state_ff == S_CHECK,
      "accepted word did not start the sequence")

endmodule

`default_nettype wire

// File: dv/tb_modular_inverse_euclid.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_modular_inverse_euclid
// Self-checking bench for the extended Euclidean modular inverse block.
// A queue of request words feeds a clocked driver. A clocked monitor compares
// each response word field by field with a prediction made at acceptance.
// Both sides idle in several phases, and one long receiver hold-off fills
// the block so that it stalls its input.
// ---------------------------------------------------------------------------

module tb_modular_inverse_euclid;

   localparam int  NUM_RANDOM  = 400;
   localparam int  HOLD_CYCLES = 5000;
   localparam int  DRAIN_WAIT  = 2000;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [30:0] value;
      logic [30:0] modulus;
   } req_word_type;

   typedef struct packed {
      logic [30:0]        gcd_value;
      logic               inverse_exists;
      logic signed [31:0] bezout_coefficient;
      logic [30:0]        inverse;
      logic [5:0]         step_count;
   } inv_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [30:0] req_value = '0;
   logic [30:0] req_modulus = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [30:0] rsp_gcd_value;
   logic rsp_inverse_exists;
   logic signed [31:0] rsp_bezout_coefficient;
   logic [30:0] rsp_inverse;
   logic [5:0] rsp_step_count;

   req_word_type   pending_words[$];
   inv_result_type expected_results[$];
   int total_words = 0;
   int sent_words = 0;
   int recv_words = 0;
   int fail_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   longint cycle_count = 0;

   modular_inverse_euclid i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .req_modulus(req_modulus),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_gcd_value(rsp_gcd_value),
      .rsp_inverse_exists(rsp_inverse_exists),
      .rsp_bezout_coefficient(rsp_bezout_coefficient),
      .rsp_inverse(rsp_inverse),
      .rsp_step_count(rsp_step_count)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Extended Euclid with truncating division; the last quotient is unused.
   function automatic inv_result_type compute_inverse(input req_word_type w);
      longint a, b, q, r, m, steps, red;
      longint pend_q;
      logic signed [31:0] prev2, prev, nxt;
      logic signed [63:0] prod;
      inv_result_type res;
      a = w.modulus;
      b = w.value;
      m = a;
      prev2 = 0;
      prev = 1;
      pend_q = -1;
      steps = 0;
      while (b != 0) begin
         q = a / b;
         r = a % b;
         if (pend_q >= 0) begin
            prod = longint'(prev2) - pend_q * longint'(prev);
            nxt = prod[31:0];
            prev2 = prev;
            prev = nxt;
         end
         pend_q = q;
         a = b;
         b = r;
         steps++;
      end
      res.gcd_value = a[30:0];
      res.inverse_exists = (a == 1);
      res.bezout_coefficient = (steps == 0) ? 32'sd0 : prev;
      res.inverse = '0;
      if (a == 1 && m != 0) begin
         red = longint'(res.bezout_coefficient) % m;
         if (red < 0) red += m;
         res.inverse = red[30:0];
      end
      res.step_count = 6'(steps + 1);
      return res;
   endfunction

   // Idle chance in percent for each quarter of the run.
   function automatic int sender_idle_pct(input int idx);
      int ph;
      ph = (idx * 4) / (total_words + 1);
      return (ph == 1) ? 72 : (ph == 3) ? 17 : 0;
   endfunction

   function automatic int receiver_stall_pct(input int idx);
      int ph;
      ph = (idx * 4) / (total_words + 1);
      return (ph == 2) ? 72 : (ph == 3) ? 17 : 0;
   endfunction

   // Driver: offers the next word, holding it until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(compute_inverse({req_value, req_modulus}));
            sent_words++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct(sent_words)) begin
               req_word_type w;
               w = pending_words.pop_front();
               req_valid   <= 1'b1;
               req_value   <= w.value;
               req_modulus <= w.modulus;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each taken response word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         recv_words++;
         if (expected_results.size() == 0) begin
            $error("response word with no prediction waiting");
            fail_count++;
         end else begin
            inv_result_type e;
            e = expected_results.pop_front();
            if (rsp_gcd_value !== e.gcd_value) begin
               $error("gcd_value: expected %0d, got %0d", e.gcd_value, rsp_gcd_value);
               fail_count++;
            end
            if (rsp_inverse_exists !== e.inverse_exists) begin
               $error("inverse_exists: expected %0d, got %0d",
                      e.inverse_exists, rsp_inverse_exists);
               fail_count++;
            end
            if (rsp_bezout_coefficient !== e.bezout_coefficient) begin
               $error("bezout_coefficient: expected %0d, got %0d",
                      e.bezout_coefficient, rsp_bezout_coefficient);
               fail_count++;
            end
            if (rsp_inverse !== e.inverse) begin
               $error("inverse: expected %0d, got %0d", e.inverse, rsp_inverse);
               fail_count++;
            end
            if (rsp_step_count !== e.step_count) begin
               $error("step_count: expected %0d, got %0d", e.step_count, rsp_step_count);
               fail_count++;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off early in the run.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && sent_words >= 8) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct(recv_words));
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic add_word(input logic [30:0] v, input logic [30:0] m);
      req_word_type w;
      w.value = v;
      w.modulus = m;
      pending_words.push_back(w);
   endtask

   // Stimulus and end of run.
   initial begin
      logic [30:0] v, m;
      int sel;
      // Directed words: field extremes and the special cases.
      add_word(31'd0, 31'd7);                  // zero value
      add_word(31'd0, 31'd1);
      add_word(31'd0, MAX31);
      add_word(31'd3, 31'd7);
      add_word(31'd10, 31'd3);                 // value not below modulus
      add_word(MAX31, 31'd1000);
      add_word(31'd6, 31'd9);                  // no inverse
      add_word(31'd12, 31'd12);
      add_word(MAX31, MAX31);
      add_word(31'd5, 31'd1);                  // modulus of one
      add_word(MAX31, 31'd1);
      add_word(31'd1, MAX31);
      add_word(31'd2, MAX31);
      add_word(31'd1134903170, 31'd1836311903); // Fibonacci pair, most steps
      add_word(31'd1836311903, 31'd1134903170);
      add_word(31'h7FFF_FFFE, MAX31);
      add_word(31'h5555_5555, 31'h2AAA_AAAB);
      add_word(31'd1, 31'd0);                  // zero modulus, inverse flagged
      add_word(31'd3, 31'd0);
      add_word(31'd0, 31'd0);
      // Random words, mostly full range with a share of small operands.
      for (int i = 0; i < NUM_RANDOM; i++) begin
         sel = $urandom_range(99);
         if (sel < 60) begin
            v = 31'($urandom());
            m = 31'($urandom_range(32'h7FFF_FFFF, 1));
         end else if (sel < 80) begin
            m = 31'($urandom_range(32'h7FFF_FFFF, 1));
            v = 31'($urandom_range(m - 1, 0));
         end else if (sel < 97) begin
            v = 31'($urandom_range(1000, 0));
            m = 31'($urandom_range(1000, 1));
         end else begin
            v = 31'($urandom());
            m = (sel == 99) ? 31'd0 : 31'd1;
         end
         add_word(v, m);
      end
      total_words = pending_words.size();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && sent_words == total_words &&
            expected_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mie_pkg.sv
hw/rtl/mie_divider.sv
hw/rtl/mie_coef.sv
hw/rtl/modular_inverse_euclid.sv
dv/tb_modular_inverse_euclid.sv
